// ----- rtl/core/tft_window_fill_sequencer_core_defines.svh -----
// ----------------------------------------------------------------------------
// tft window fill sequencer assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TFT_WINDOW_FILL_SEQUENCER_CORE_DEFINES_SVH
`define TFT_WINDOW_FILL_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TWFS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twfs assertion failed");
// next-cycle implication
`define TWFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twfs assertion failed");
`else
`define TWFS_ASSERT_SAME(label, ante, cons)
`define TWFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/twfs_pkg.sv -----
// ----------------------------------------------------------------------------
// twfs_pkg
// shared types, codes and constants of the tft window fill sequencer
// ----------------------------------------------------------------------------
package twfs_pkg;

  localparam int PIXEL_COUNT_WIDTH_DEF = 18;
  localparam int CNT_RAW_W             = 18;
  localparam int APB_ADDR_W            = 4;

  localparam logic [7:0] PANEL_WIDTH_RST  = 8'd128;
  localparam logic [7:0] PANEL_HEIGHT_RST = 8'd160;
  localparam logic [7:0] GRID_LAST_RST    = 8'd19;

  localparam logic [7:0] CMD_COL_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR  = 8'h2C;

  typedef enum logic [2:0] {
    REQ_TICK,
    REQ_RECT,
    REQ_GRID,
    REQ_PIXEL,
    REQ_FULL
  } req_code_t;

  typedef enum logic [1:0] {
    REG_PANEL_WIDTH,
    REG_PANEL_HEIGHT,
    REG_GRID_LAST
  } reg_idx_t;

  typedef enum logic [3:0] {
    HDR_COL_CMD,
    HDR_COL_START_HI,
    HDR_COL_START_LO,
    HDR_COL_END_HI,
    HDR_COL_END_LO,
    HDR_ROW_CMD,
    HDR_ROW_START_HI,
    HDR_ROW_START_LO,
    HDR_ROW_END_HI,
    HDR_ROW_END_LO,
    HDR_MEM_CMD,
    HDR_PIXELS
  } hdr_pos_t;

  typedef struct packed {
    logic [7:0] panel_width;
    logic [7:0] panel_height;
    logic [7:0] grid_last_index;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [8:0]  size_w;
    logic [8:0]  size_h;
    logic [7:0]  block_side;
    logic [7:0]  grid_col;
    logic [7:0]  grid_row;
    logic [15:0] color;
  } req_t;

  typedef struct packed {
    logic                 tick;
    logic                 start;
    logic [15:0]          col_start;
    logic [15:0]          col_end;
    logic [15:0]          row_start;
    logic [15:0]          row_end;
    logic [CNT_RAW_W-1:0] count;
    logic [15:0]          color;
  } fill_t;

endpackage

// ----- rtl/core/twfs_if.sv -----
// ----------------------------------------------------------------------------
// twfs channel interfaces
// request channel and output byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface twfs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [8:0]  size_w;
  logic [8:0]  size_h;
  logic [7:0]  block_side;
  logic [7:0]  grid_col;
  logic [7:0]  grid_row;
  logic [15:0] color;

  modport source (
    output valid, req_type, pos_x, pos_y, size_w, size_h, block_side, grid_col,
           grid_row, color,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, size_w, size_h, block_side, grid_col,
           grid_row, color,
    output ready
  );
endinterface

interface twfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       data_mode;
  logic       last_byte;

  modport source (
    output valid, spi_byte, data_mode, last_byte,
    input  ready
  );
  modport sink (
    input  valid, spi_byte, data_mode, last_byte,
    output ready
  );
endinterface

// ----- rtl/core/twfs_cfg.sv -----
// ----------------------------------------------------------------------------
// twfs_cfg
// apb configuration registers: panel size and grid flip index
// ----------------------------------------------------------------------------
module twfs_cfg import twfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_width     <= PANEL_WIDTH_RST;
      cfg.panel_height    <= PANEL_HEIGHT_RST;
      cfg.grid_last_index <= GRID_LAST_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PANEL_WIDTH:  cfg.panel_width     <= pwdata[7:0];
        REG_PANEL_HEIGHT: cfg.panel_height    <= pwdata[7:0];
        REG_GRID_LAST:    cfg.grid_last_index <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PANEL_WIDTH:  prdata = {24'd0, cfg.panel_width};
      REG_PANEL_HEIGHT: prdata = {24'd0, cfg.panel_height};
      REG_GRID_LAST:    prdata = {24'd0, cfg.grid_last_index};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/twfs_window.sv -----
// ----------------------------------------------------------------------------
// twfs_window
// window corner and pixel count calculation for one registered request
// ----------------------------------------------------------------------------
module twfs_window import twfs_pkg::*; (
  input  req_t  req,
  input  cfg_t  cfg,
  output fill_t fill
);

  logic [7:0]  half_w;
  logic [7:0]  half_h;
  logic [17:0] rect_count;
  logic [15:0] bs16;
  logic [15:0] pw16;
  logic [15:0] ph16;
  logic [15:0] grid_x_flip;
  logic [15:0] grid_y_flip;
  logic [15:0] grid_x_off;
  logic [15:0] grid_y_off;
  logic [15:0] grid_x;
  logic [15:0] grid_y;
  logic [15:0] grid_count;
  logic [15:0] full_count;

  assign half_w      = req.size_w[8:1];
  assign half_h      = req.size_h[8:1];
  assign rect_count  = 18'({half_w, 1'b0}) * 18'({half_h, 1'b0});
  assign bs16        = {8'd0, req.block_side};
  assign pw16        = {8'd0, cfg.panel_width};
  assign ph16        = {8'd0, cfg.panel_height};
  assign grid_x_flip = {8'd0, cfg.grid_last_index} - {8'd0, req.grid_row};
  assign grid_y_flip = {8'd0, cfg.grid_last_index} - {8'd0, req.grid_col};
  assign grid_x_off  = grid_x_flip * bs16;
  assign grid_y_off  = grid_y_flip * bs16;
  assign grid_x      = req.pos_x + grid_x_off;
  assign grid_y      = req.pos_y + grid_y_off;
  assign grid_count  = bs16 * bs16;
  assign full_count  = pw16 * ph16;

  always_comb begin
    fill.tick      = 1'b0;
    fill.start     = 1'b0;
    fill.col_start = req.pos_x;
    fill.col_end   = req.pos_x;
    fill.row_start = req.pos_y;
    fill.row_end   = req.pos_y;
    fill.count     = '0;
    fill.color     = req.color;
    unique case (req_code_t'(req.req_type))
      REQ_TICK: fill.tick = 1'b1;
      REQ_RECT: begin
        fill.start     = 1'b1;
        fill.col_start = req.pos_x - {8'd0, half_w};
        fill.col_end   = req.pos_x + {8'd0, half_w} - 16'd1;
        fill.row_start = req.pos_y - {8'd0, half_h};
        fill.row_end   = req.pos_y + {8'd0, half_h} - 16'd1;
        fill.count     = CNT_RAW_W'(rect_count);
      end
      REQ_GRID: begin
        fill.start     = 1'b1;
        fill.col_start = grid_x;
        fill.col_end   = grid_x + bs16 - 16'd1;
        fill.row_start = grid_y;
        fill.row_end   = grid_y + bs16 - 16'd1;
        fill.count     = CNT_RAW_W'(grid_count);
      end
      REQ_PIXEL: begin
        // off-panel pixel starts nothing
        fill.start = (req.pos_x < pw16) && (req.pos_y < ph16);
        fill.count = CNT_RAW_W'(1'b1);
      end
      REQ_FULL: begin
        fill.start     = 1'b1;
        fill.col_start = 16'd0;
        fill.col_end   = pw16 - 16'd1;
        fill.row_start = 16'd0;
        fill.row_end   = ph16 - 16'd1;
        fill.count     = CNT_RAW_W'(full_count);
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/twfs_seq.sv -----
// ----------------------------------------------------------------------------
// twfs_seq
// fill state, header and pixel byte sequencing, output byte register
// ----------------------------------------------------------------------------
`include "tft_window_fill_sequencer_core_defines.svh"

module twfs_seq import twfs_pkg::*; #(
  parameter int PIXEL_COUNT_WIDTH = PIXEL_COUNT_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  fill_t          fill,
  output logic           out_free,
  twfs_byte_if.source    spi
);

  localparam int CW = PIXEL_COUNT_WIDTH;
  localparam int EW = (CW > CNT_RAW_W) ? CW : CNT_RAW_W;

  logic          busy;
  logic          busy_next;
  hdr_pos_t      hdr_idx;
  hdr_pos_t      hdr_next;
  logic          low_half;
  logic          low_next;
  logic [CW-1:0] pixels_left;
  logic [CW-1:0] pixels_left_next;
  logic [15:0]   fill_color;
  logic [15:0]   col_start;
  logic [15:0]   col_end;
  logic [15:0]   row_start;
  logic [15:0]   row_end;

  logic [EW-1:0] count_ext;
  logic [EW-1:0] count_max;
  logic [CW-1:0] count_sat;
  logic [CW-1:0] pixels_dec;
  logic          start_go;
  logic          emit;
  logic [7:0]    out_byte;
  logic          out_data;
  logic          out_last;

  assign out_free   = !spi.valid || spi.ready;
  assign start_go   = step && fill.start && !busy;
  assign emit       = step && fill.tick && busy;

  // clamp the pixel count to the counter range
  assign count_ext  = EW'(fill.count);
  assign count_max  = EW'({CW{1'b1}});
  assign count_sat  = (count_ext > count_max) ? count_max[CW-1:0] : count_ext[CW-1:0];
  assign pixels_dec = (pixels_left != '0) ? pixels_left - CW'(1'b1) : '0;

  always_comb begin
    busy_next        = busy;
    hdr_next         = hdr_idx;
    low_next         = low_half;
    pixels_left_next = pixels_left;
    out_byte         = CMD_MEM_WR;
    out_data         = 1'b0;
    out_last         = 1'b0;
    if (start_go) begin
      busy_next        = 1'b1;
      hdr_next         = HDR_COL_CMD;
      low_next         = 1'b0;
      pixels_left_next = count_sat;
    end else if (emit) begin
      if (hdr_idx != HDR_PIXELS) begin
        hdr_next = hdr_pos_t'(hdr_idx + 4'd1);
        out_data = 1'b1;
        unique case (hdr_idx)
          HDR_COL_CMD: begin
            out_byte = CMD_COL_SET;
            out_data = 1'b0;
          end
          HDR_COL_START_HI: out_byte = col_start[15:8];
          HDR_COL_START_LO: out_byte = col_start[7:0];
          HDR_COL_END_HI:   out_byte = col_end[15:8];
          HDR_COL_END_LO:   out_byte = col_end[7:0];
          HDR_ROW_CMD: begin
            out_byte = CMD_ROW_SET;
            out_data = 1'b0;
          end
          HDR_ROW_START_HI: out_byte = row_start[15:8];
          HDR_ROW_START_LO: out_byte = row_start[7:0];
          HDR_ROW_END_HI:   out_byte = row_end[15:8];
          HDR_ROW_END_LO:   out_byte = row_end[7:0];
          HDR_MEM_CMD: begin
            out_byte = CMD_MEM_WR;
            out_data = 1'b0;
            out_last = (pixels_left == '0);
          end
          default: begin
            out_byte = CMD_MEM_WR;
            out_data = 1'b0;
          end
        endcase
      end else begin
        out_data = 1'b1;
        if (!low_half) begin
          out_byte = fill_color[15:8];
          low_next = 1'b1;
        end else begin
          out_byte         = fill_color[7:0];
          low_next         = 1'b0;
          pixels_left_next = pixels_dec;
          out_last         = (pixels_dec == '0);
        end
      end
      if (out_last) begin
        busy_next = 1'b0;
        hdr_next  = HDR_COL_CMD;
        low_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      hdr_idx     <= HDR_COL_CMD;
      low_half    <= 1'b0;
      pixels_left <= '0;
      fill_color  <= 16'd0;
    end else begin
      busy        <= busy_next;
      hdr_idx     <= hdr_next;
      low_half    <= low_next;
      pixels_left <= pixels_left_next;
      if (start_go) begin
        fill_color <= fill.color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_go) begin
      col_start <= fill.col_start;
      col_end   <= fill.col_end;
      row_start <= fill.row_start;
      row_end   <= fill.row_end;
    end
  end

  // output byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      spi.valid <= 1'b0;
    end else if (step) begin
      spi.valid <= emit;
    end else if (spi.ready) begin
      spi.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      spi.spi_byte  <= out_byte;
      spi.data_mode <= out_data;
      spi.last_byte <= out_last;
    end
  end

  `TWFS_ASSERT_SAME(a_idle_clean, !busy, (hdr_idx == HDR_COL_CMD) && !low_half)
  `TWFS_ASSERT_SAME(a_hdr_no_low, busy && (hdr_idx != HDR_PIXELS), !low_half)
  `TWFS_ASSERT_NEXT(a_last_idle, emit && out_last, !busy)
  `TWFS_ASSERT_NEXT(a_start_busy, start_go, busy && (hdr_idx == HDR_COL_CMD))

endmodule

// ----- rtl/core/tft_window_fill_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// tft_window_fill_sequencer_core
// command and data byte sequencer for a tft panel window fill
// ----------------------------------------------------------------------------
// req channel: one transaction per request; req_type selects a tick or one of
//   four fill starts (rectangle by centre, grid block, clipped pixel, full
//   screen). a start while a fill is running is dropped without a result.
// spi channel: each tick during a fill yields one byte: column set, row set,
//   memory write header, then colour high/low bytes for every pixel, with
//   data_mode and last_byte flags. ticks while idle yield nothing.
// apb port: panel_width at 0x0, panel_height at 0x4, grid_last_index at 0x8;
//   write only while the block is idle.
// path: the input register takes the tick, then the output byte register takes
//   the byte once the output register is free.
// throughput: one transaction per cycle, sustained while no output byte is held.
// reset: registers return to 128, 160 and 19, the sequencer goes idle and the
//   output register empties.
// stall: a held output byte blocks the input register; req.ready falls once
//   both are full and rises again the cycle spi.ready returns.
// ----------------------------------------------------------------------------
module tft_window_fill_sequencer_core import twfs_pkg::*; #(
  parameter int PIXEL_COUNT_WIDTH = PIXEL_COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  twfs_req_if.sink              req,
  twfs_byte_if.source           spi,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t  cfg;
  req_t  req_q;
  fill_t fill;
  logic  req_valid_q;
  logic  out_free;
  logic  step;
  logic  in_ready;

  assign step      = req_valid_q && out_free;
  assign in_ready  = !req_valid_q || step;
  assign req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid_q <= 1'b0;
    end else if (in_ready) begin
      req_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && in_ready) begin
      req_q.req_type   <= req.req_type;
      req_q.pos_x      <= req.pos_x;
      req_q.pos_y      <= req.pos_y;
      req_q.size_w     <= req.size_w;
      req_q.size_h     <= req.size_h;
      req_q.block_side <= req.block_side;
      req_q.grid_col   <= req.grid_col;
      req_q.grid_row   <= req.grid_row;
      req_q.color      <= req.color;
    end
  end

  twfs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  twfs_window u_window (
    .req  (req_q),
    .cfg  (cfg),
    .fill (fill)
  );

  twfs_seq #(
    .PIXEL_COUNT_WIDTH (PIXEL_COUNT_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .fill     (fill),
    .out_free (out_free),
    .spi      (spi)
  );

endmodule
